// ===== rtl/core/alc_pkg.sv =====
// Package with shared types and constants of the associative LRU tag cache.
`default_nettype none
package alc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int IDX_W       = $clog2(ENTRIES_DEF);
  localparam int TAG_W       = 48;
  localparam int STAMP_W     = 32;
  localparam int CNT_W       = 16;
  localparam int SLOT_W      = 6;

  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_FILL    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               inv;
    logic [IDX_W-1:0]   inv_idx;
    logic [IDX_W-1:0]   best_idx;
    logic [STAMP_W-1:0] best_stamp;
  } probe_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               touch;
    logic               clear;
    logic               install;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  function automatic logic older(input logic [STAMP_W-1:0] a, input logic [STAMP_W-1:0] b);
    logic [STAMP_W-1:0] d;
    d = a - b;
    return d[STAMP_W-1];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/assoc_lru_tag_cache_top.sv =====
// Top level of the fully associative LRU tag cache with its sequencing control.
// The block keeps up to ENTRIES tags (item index, ink, paper) in a row of cells.
// Input transactions carry the operation in in_tuser and the tag and fill flags
// in in_tdata: a lookup, a request that records a pending tag on a miss, or a
// fill that installs the pending tag into the first invalid or the oldest slot.
// The cfg channel writes item_count; it is always ready and must only be used
// while the block is idle. Zero disables every operation.
// Every input transaction gives exactly one result transaction on out_tdata.
// An operation that needs the tag store sends a probe down the cell row, one
// cell per cycle, and its result goes to the output register after the probe
// leaves the last cell; a rejected operation goes from acceptance straight to
// ST_RESP. One item is in work at a time.
// The next input is accepted as soon as the previous result is in the output
// register. When the receiver stalls, the result holds and the next finished
// result waits until out_tready takes the old one.
// After rst_n all entries are invalid, no tag is pending, the touch counter
// and item_count are zero.
`default_nettype none
module assoc_lru_tag_cache_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Bits from low: item_index[15:0], ink_colour[31:16], paper_colour[47:32],
  // fetch_ok[48], render_ok[49], zero fill.
  input  wire logic [55:0] in_tdata,
  // Bits from low: func[1:0].
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Bits from low: accepted[0], hit[1], slot[7:2], pending_set[8], installed[9],
  // victim_cleared[10], zero fill.
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int ENTRIES = alc_pkg::ENTRIES_DEF;

  alc_pkg::state_t state_r, state_nxt;
  alc_pkg::probe_t probe_w [0:ENTRIES];
  alc_pkg::wr_t    wr_w;

  logic [alc_pkg::CNT_W-1:0]   count_r;
  logic [alc_pkg::STAMP_W-1:0] touch_r;
  logic                        pend_vld_r;
  logic [alc_pkg::TAG_W-1:0]   pend_tag_r;
  logic [1:0]                  func_r;
  logic [alc_pkg::TAG_W-1:0]   tag_r;
  logic                        render_r;
  logic                        imm_r;
  logic                        acc_r;
  logic                        hit_r;
  logic [alc_pkg::IDX_W-1:0]   hit_idx_r;
  logic [alc_pkg::IDX_W-1:0]   victim_r;
  logic                        out_valid_r;
  logic [15:0]                 out_data_r;

  logic                        in_fire;
  logic                        resp_fire;
  logic                        launch;
  logic                        imm;
  logic                        acc;
  logic                        take_pend;
  logic [alc_pkg::TAG_W-1:0]   launch_tag;
  logic [1:0]                  func;
  logic [15:0]                 item;
  logic [15:0]                 pend_item;
  logic                        in_range;

  logic                        res_hit;
  logic [alc_pkg::SLOT_W-1:0]  res_slot;
  logic                        res_pend;
  logic                        res_inst;
  logic                        res_clr;

  assign func      = in_tuser;
  assign item      = in_tdata[15:0];
  assign pend_item = pend_tag_r[47:32];
  assign in_range  = (count_r != 16'd0) && (item < count_r);
  assign in_fire   = in_tvalid && in_tready;
  assign resp_fire = (state_r == alc_pkg::ST_RESP) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_comb begin
    imm        = 1'b1;
    acc        = 1'b0;
    take_pend  = 1'b0;
    launch_tag = {in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]};
    case (func)
      alc_pkg::FUNC_LOOKUP, alc_pkg::FUNC_REQUEST: begin
        if (in_range) begin
          imm = 1'b0;
          acc = 1'b1;
        end
      end
      alc_pkg::FUNC_FILL: begin
        if (count_r != 16'd0 && pend_vld_r) begin
          acc        = 1'b1;
          take_pend  = 1'b1;
          launch_tag = pend_tag_r;
          if (pend_item < count_r && in_tdata[48]) begin
            imm = 1'b0;
          end
        end
      end
      default: begin
        imm = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = imm ? alc_pkg::ST_RESP : alc_pkg::ST_SCAN;
        end
      end
      alc_pkg::ST_SCAN: begin
        if (probe_w[ENTRIES].vld) begin
          state_nxt = alc_pkg::ST_RESP;
        end
      end
      alc_pkg::ST_RESP: begin
        if (resp_fire) begin
          state_nxt = alc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = alc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = (state_r == alc_pkg::ST_IDLE);
    launch    = in_fire && !imm;
    res_hit   = 1'b0;
    res_slot  = '0;
    res_pend  = 1'b0;
    res_inst  = 1'b0;
    res_clr   = 1'b0;
    wr_w      = '{idx: victim_r, touch: 1'b0, clear: 1'b0, install: 1'b0,
                  tag: tag_r, stamp: touch_r + 32'd1};
    if (!imm_r) begin
      if (func_r == alc_pkg::FUNC_FILL) begin
        res_slot = alc_pkg::SLOT_W'(victim_r);
        res_clr  = 1'b1;
        res_inst = render_r;
        wr_w.clear   = resp_fire;
        wr_w.install = resp_fire && render_r;
      end else if (hit_r) begin
        res_hit    = 1'b1;
        res_slot   = alc_pkg::SLOT_W'(hit_idx_r);
        wr_w.idx   = hit_idx_r;
        wr_w.touch = resp_fire;
      end else if (func_r == alc_pkg::FUNC_REQUEST) begin
        res_pend = 1'b1;
      end
    end
  end

  assign probe_w[0] = '{vld: launch, tag: launch_tag, hit: 1'b0, hit_idx: '0,
                        inv: 1'b0, inv_idx: '0, best_idx: '0, best_stamp: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    alc_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .probe_i (probe_w[g]),
      .wr_i    (wr_w),
      .probe_o (probe_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alc_pkg::ST_IDLE;
      count_r     <= '0;
      touch_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      if (in_fire && take_pend) begin
        pend_vld_r <= 1'b0;
      end
      if (resp_fire) begin
        out_valid_r <= 1'b1;
        if (res_pend) begin
          pend_vld_r <= 1'b1;
        end
        if (wr_w.touch || wr_w.install) begin
          touch_r <= touch_r + 32'd1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      func_r   <= func;
      tag_r    <= launch_tag;
      render_r <= in_tdata[49];
      imm_r    <= imm;
      acc_r    <= acc;
    end
    if (state_r == alc_pkg::ST_SCAN && probe_w[ENTRIES].vld) begin
      hit_r     <= probe_w[ENTRIES].hit;
      hit_idx_r <= probe_w[ENTRIES].hit_idx;
      victim_r  <= probe_w[ENTRIES].inv ? probe_w[ENTRIES].inv_idx
                                        : probe_w[ENTRIES].best_idx;
    end
    if (resp_fire) begin
      if (res_pend) begin
        pend_tag_r <= tag_r;
      end
      out_data_r <= {5'd0, res_clr, res_inst, res_pend, res_slot, res_hit, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/alc_cell.sv =====
// One cache entry that updates a passing search probe and hands it to the next entry.
`default_nettype none
module alc_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  alc_pkg::probe_t    probe_i,
  input  alc_pkg::wr_t       wr_i,
  output alc_pkg::probe_t    probe_o
);

  logic                        valid_r;
  logic [alc_pkg::TAG_W-1:0]   tag_r;
  logic [alc_pkg::STAMP_W-1:0] stamp_r;
  alc_pkg::probe_t             probe_r;
  alc_pkg::probe_t             probe_nxt;
  logic [alc_pkg::IDX_W-1:0]   my_idx;

  assign my_idx = alc_pkg::IDX_W'(IDX);

  always_comb begin
    probe_nxt = probe_i;
    if (valid_r && tag_r == probe_i.tag && !probe_i.hit) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.hit_idx = my_idx;
    end
    if (!valid_r) begin
      if (!probe_i.inv) begin
        probe_nxt.inv     = 1'b1;
        probe_nxt.inv_idx = my_idx;
      end
    end else if (IDX == 0 || alc_pkg::older(stamp_r, probe_i.best_stamp)) begin
      probe_nxt.best_idx   = my_idx;
      probe_nxt.best_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
      if (wr_i.idx == my_idx) begin
        if (wr_i.clear) begin
          valid_r <= 1'b0;
        end
        if (wr_i.install) begin
          valid_r <= 1'b1;
        end
      end
    end
    probe_r.tag        <= probe_nxt.tag;
    probe_r.hit        <= probe_nxt.hit;
    probe_r.hit_idx    <= probe_nxt.hit_idx;
    probe_r.inv        <= probe_nxt.inv;
    probe_r.inv_idx    <= probe_nxt.inv_idx;
    probe_r.best_idx   <= probe_nxt.best_idx;
    probe_r.best_stamp <= probe_nxt.best_stamp;
    if (wr_i.idx == my_idx) begin
      if (wr_i.install) begin
        tag_r <= wr_i.tag;
      end
      if (wr_i.install || wr_i.touch) begin
        stamp_r <= wr_i.stamp;
      end
    end
  end

  assign probe_o = probe_r;

endmodule
`default_nettype wire

// ===== test/tb_assoc_lru_tag_cache_top.sv =====
// Self-checking stream testbench for the associative LRU tag cache top level.
`default_nettype none
module tb_assoc_lru_tag_cache_top;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] item;
    logic [15:0] ink;
    logic [15:0] paper;
    logic        fetch_ok;
    logic        render_ok;
  } op_t;

  typedef struct {
    logic       accepted;
    logic       hit;
    logic [5:0] slot;
    logic       pending_set;
    logic       installed;
    logic       victim_cleared;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  assoc_lru_tag_cache_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  op_t         op_q[$];
  outcome_t    outcome_q[$];
  op_t         op_on_bus;
  int          errors = 0;
  int          ops_taken = 0;

  // Shadow copy of the tag store.
  logic        sh_valid[64];
  logic [15:0] sh_item[64];
  logic [15:0] sh_ink[64];
  logic [15:0] sh_paper[64];
  logic [31:0] sh_stamp[64];
  logic [31:0] sh_counter = '0;
  logic        sh_pend_vld = 1'b0;
  op_t         sh_pend;
  logic [15:0] sh_count = '0;

  initial begin
    for (int i = 0; i < 64; i++) sh_valid[i] = 1'b0;
  end

  function automatic outcome_t cache_predict(op_t it);
    outcome_t r;
    int s;
    int v;
    int best;
    logic [31:0] d;
    r = '{default: 1'b0};
    if (it.func == alc_pkg::FUNC_LOOKUP || it.func == alc_pkg::FUNC_REQUEST) begin
      if (sh_count == 0 || it.item >= sh_count) return r;
      r.accepted = 1'b1;
      s = -1;
      for (int i = 0; i < 64; i++)
        if (s < 0 && sh_valid[i] && sh_item[i] == it.item && sh_ink[i] == it.ink &&
            sh_paper[i] == it.paper) s = i;
      if (s >= 0) begin
        sh_counter = sh_counter + 1;
        sh_stamp[s] = sh_counter;
        r.hit = 1'b1;
        r.slot = s[5:0];
      end else if (it.func == alc_pkg::FUNC_REQUEST) begin
        sh_pend_vld = 1'b1;
        sh_pend = it;
        r.pending_set = 1'b1;
      end
    end else if (it.func == alc_pkg::FUNC_FILL) begin
      if (sh_count == 0 || !sh_pend_vld) return r;
      sh_pend_vld = 1'b0;
      r.accepted = 1'b1;
      if (sh_pend.item >= sh_count || !it.fetch_ok) return r;
      v = -1;
      best = 0;
      for (int i = 0; i < 64; i++) begin
        if (v < 0) begin
          if (!sh_valid[i]) v = i;
          else begin
            d = sh_stamp[i] - sh_stamp[best];
            if (d[31]) best = i;
          end
        end
      end
      if (v < 0) v = best;
      sh_valid[v] = 1'b0;
      r.slot = v[5:0];
      r.victim_cleared = 1'b1;
      if (it.render_ok) begin
        sh_item[v] = sh_pend.item;
        sh_ink[v] = sh_pend.ink;
        sh_paper[v] = sh_pend.paper;
        sh_valid[v] = 1'b1;
        sh_counter = sh_counter + 1;
        sh_stamp[v] = sh_counter;
        r.installed = 1'b1;
      end
    end
    return r;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  logic in_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (op_q.size() > 0) begin
        op_on_bus = op_q.pop_front();
        in_tdata <= {6'b0, op_on_bus.render_ok, op_on_bus.fetch_ok, op_on_bus.paper,
                     op_on_bus.ink, op_on_bus.item};
        in_tuser <= op_on_bus.func;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off.
  int  rx_mode = 0;
  int  rx_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles % 300 == 0) rx_mode <= $urandom_range(0, 2);
      if (!hold_done && ops_taken >= 450) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk) begin
    outcome_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      outcome_q.push_back(cache_predict(op_on_bus));
      ops_taken <= ops_taken + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (out_tdata[0] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_tdata[1]);
          errors++;
        end
        if (out_tdata[7:2] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[7:2]);
          errors++;
        end
        if (out_tdata[8] !== want.pending_set) begin
          $error("pending_set: expected %0d, got %0d", want.pending_set, out_tdata[8]);
          errors++;
        end
        if (out_tdata[9] !== want.installed) begin
          $error("installed: expected %0d, got %0d", want.installed, out_tdata[9]);
          errors++;
        end
        if (out_tdata[10] !== want.victim_cleared) begin
          $error("victim_cleared: expected %0d, got %0d", want.victim_cleared,
                 out_tdata[10]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_op(logic [1:0] func, logic [15:0] item, logic [15:0] ink,
                        logic [15:0] paper, logic fetch_ok, logic render_ok);
    op_t it;
    it.func = func;
    it.item = item;
    it.ink = ink;
    it.paper = paper;
    it.fetch_ok = fetch_ok;
    it.render_ok = render_ok;
    op_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (op_q.size() > 0 || in_tvalid || outcome_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_count(logic [15:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly request/fill traffic over a tag pool a bit larger than the store.
  task automatic add_random(int n);
    logic [15:0] p_item[80];
    logic [15:0] p_ink[80];
    logic [15:0] p_paper[80];
    int k;
    int pick;
    for (int i = 0; i < 80; i++) begin
      p_item[i] = (sh_count == 0) ? 16'($urandom) : 16'($urandom_range(0, sh_count - 1));
      p_ink[i] = 16'($urandom);
      p_paper[i] = 16'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 79);
      pick = $urandom_range(0, 99);
      if (pick < 25)
        add_op(alc_pkg::FUNC_LOOKUP, p_item[k], p_ink[k], p_paper[k], 1'b0, 1'b0);
      else if (pick < 55)
        add_op(alc_pkg::FUNC_REQUEST,
               ($urandom_range(0, 9) == 0) ? 16'($urandom) : p_item[k],
               p_ink[k], p_paper[k], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 93)
        add_op(alc_pkg::FUNC_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
               $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
      else
        add_op(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_op(alc_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_REQUEST, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    wait_idle();

    write_count(16'hFFFF);
    add_op(alc_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_REQUEST, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_REQUEST, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_REQUEST, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_REQUEST, 16'hFFFF, 16'h1234, 16'h5678, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_LOOKUP, 16'hFFFF, 16'h1234, 16'h5678, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_REQUEST, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    add_op(alc_pkg::FUNC_REQUEST, 16'h0032, 16'h00AA, 16'h0055, 1'b0, 1'b0);
    wait_idle();

    // Disabled: the fill must leave the pending tag in place.
    write_count(16'h0000);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    wait_idle();

    // The pending index is now out of range, so the fill only consumes it.
    write_count(16'd40);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_REQUEST, 16'd3, 16'h0001, 16'h0002, 1'b0, 1'b0);
    add_op(alc_pkg::FUNC_FILL, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    add_op(alc_pkg::FUNC_LOOKUP, 16'd40, 16'h0001, 16'h0002, 1'b0, 1'b0);
    add_random(400);
    wait_idle();

    write_count(16'hFFFF);
    add_random(300);
    wait_idle();

    write_count(16'd1);
    add_random(150);
    wait_idle();

    write_count(16'($urandom_range(2, 300)));
    add_random(250);
    wait_idle();

    write_count(16'd100);
    add_random(150);
    wait_idle();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/alc_pkg.sv
rtl/core/alc_cell.sv
rtl/core/assoc_lru_tag_cache_top.sv
test/tb_assoc_lru_tag_cache_top.sv
